/* hdl/rbd_pkg.sv */
// rbd_pkg: shared types and constants for the rgba 2x2 box downsampler
// no dependencies; imported by rbd_pos and the top-level core

package rbd_pkg;

  // configuration register width and register indexes
  localparam int SIZE_W = 13;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b1;

  // size limits
  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // channel and sum widths
  localparam int CH_W = 8;
  localparam int NUM_CH = 4;
  localparam int PIX_W = CH_W * NUM_CH;
  localparam int PSUM_W = CH_W + 1;
  localparam int LINE_W = PSUM_W * NUM_CH;

  // per-beat position decode from the position tracker
  typedef struct packed {
    logic enabled;   // image large enough to give output
    logic in_image;  // pixel lies inside the even-sized area
    logic odd_col;
    logic odd_row;
    logic last;      // final 2x2 block of the image
  } pos_ctl_t;

endpackage

/* hdl/rbd_ram.sv */
// rbd_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module rbd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 2048,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/rbd_pos.sv */
// rbd_pos: column and row position tracking with wrap at image end
// depends on rbd_pkg

module rbd_pos import rbd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int CMP_W = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W,
  localparam int LINE_DEPTH = MAX_WIDTH / 2,
  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [SIZE_W-1:0] row_width,
  input  logic [SIZE_W-1:0] row_count,
  output pos_ctl_t          ctl,
  output logic [ADDR_W-1:0] line_addr
);

  logic [COL_W-1:0] column_pos, column_pos_next;
  logic [ROW_W-1:0] row_pos, row_pos_next;

  logic [CMP_W-1:0]  w_sat, used_w, col_x;
  logic [SIZE_W-1:0] h_sat, used_h, row_x;
  logic [COL_W-1:0]  col_half;
  logic              col_end, row_end;

  // saturate sizes and round them down to even
  always_comb begin
    w_sat = (CMP_W'(row_width) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : CMP_W'(row_width);
    h_sat = (row_count > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : row_count;
    used_w = {w_sat[CMP_W-1:1], 1'b0};
    used_h = {h_sat[SIZE_W-1:1], 1'b0};
    col_x = CMP_W'(column_pos);
    row_x = SIZE_W'(row_pos);
  end

  // decode the current position
  always_comb begin
    ctl.enabled  = (w_sat >= CMP_W'(2)) && (h_sat >= SIZE_W'(2));
    ctl.in_image = (col_x < used_w) && (row_x < used_h);
    ctl.odd_col  = column_pos[0];
    ctl.odd_row  = row_pos[0];
    ctl.last     = (row_x == used_h - SIZE_W'(1)) && (col_x == used_w - CMP_W'(1));
    col_half     = column_pos >> 1;
    line_addr    = ADDR_W'(col_half);
    col_end      = col_x >= w_sat - CMP_W'(1);
    row_end      = row_x >= h_sat - SIZE_W'(1);
  end

  // next position
  always_comb begin
    column_pos_next = column_pos;
    row_pos_next = row_pos;
    if (advance && ctl.enabled) begin
      if (col_end) begin
        column_pos_next = '0;
        row_pos_next = row_end ? '0 : row_pos + ROW_W'(1);
      end else begin
        column_pos_next = column_pos + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos <= '0;
      row_pos <= '0;
    end else begin
      column_pos <= column_pos_next;
      row_pos <= row_pos_next;
    end
  end

endmodule

/* hdl/rgba_box_downsample_2x_core.sv */
// rgba_box_downsample_2x_core: top level of the 2x2 rgba box downsampler
// depends on rbd_pkg, rbd_pos and rbd_ram

// Takes one rgba8 source pixel per clock in raster order while the output is
// not stalled, and gives one pixel per 2x2 block, each channel the truncated
// mean of the four samples. Stalls come only from the output side: the result
// of a block is registered as the second pixel of its odd-row pair is taken,
// and a new beat is taken while a result waits as long as the output register
// drains in the same cycle. The line buffer holds the horizontal pair sums of
// the even row; its registered read is issued on the first pixel of each
// odd-row pair so the data is ready for the second. The last result of an
// image carries tlast. Odd trailing columns and rows are consumed and dropped;
// an image narrower or shorter than two gives nothing. The user must set sizes
// through the configuration port while idle; the block does not enforce this.

module rgba_box_downsample_2x_core import rbd_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int LINE_DEPTH = MAX_WIDTH / 2,
  localparam int ADDR_W = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  // source pixels
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [PIX_W-1:0]     s_axis_tdata,  // red_in, green_in, blue_in, alpha_in
  // downsampled pixels
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [PIX_W-1:0]     m_axis_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                 m_axis_tlast   // image_done
);

  logic [SIZE_W-1:0] row_width, row_count;
  logic [PIX_W-1:0]  held_pixel;
  logic [LINE_W-1:0] pair_sum, line_rdata;
  logic [PIX_W-1:0]  avg;
  logic              s_fire, active, take_first, write_line, out_load;
  pos_ctl_t          ctl;
  logic [ADDR_W-1:0] line_addr;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= '0;
      row_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_WIDTH: row_width <= cfg_data;
        REG_ROW_COUNT: row_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // input handshake
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  rbd_pos #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_pos (
    .clk(clk),
    .rst(rst),
    .advance(s_fire),
    .row_width(row_width),
    .row_count(row_count),
    .ctl(ctl),
    .line_addr(line_addr)
  );

  // beat classification
  always_comb begin
    active     = s_fire && ctl.enabled && ctl.in_image;
    take_first = active && !ctl.odd_col;
    write_line = active && ctl.odd_col && !ctl.odd_row;
    out_load   = active && ctl.odd_col && ctl.odd_row;
  end

  // horizontal pair sums and 2x2 means
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      pair_sum[c*PSUM_W +: PSUM_W] = PSUM_W'(held_pixel[c*CH_W +: CH_W])
                                   + PSUM_W'(s_axis_tdata[c*CH_W +: CH_W]);
      avg[c*CH_W +: CH_W] = CH_W'(((PSUM_W + 1)'(line_rdata[c*PSUM_W +: PSUM_W])
                                 + (PSUM_W + 1)'(pair_sum[c*PSUM_W +: PSUM_W])) >> 2);
    end
  end

  // first pixel of each pair
  always_ff @(posedge clk) begin
    if (rst) begin
      held_pixel <= '0;
    end else if (take_first) begin
      held_pixel <= s_axis_tdata;
    end
  end

  // even-row pair sums, read back on odd rows
  rbd_ram #(
    .WIDTH(LINE_W),
    .DEPTH(LINE_DEPTH)
  ) u_line (
    .clk(clk),
    .we(write_line),
    .waddr(line_addr),
    .wdata(pair_sum),
    .re(take_first && ctl.odd_row),
    .raddr(line_addr),
    .rdata(line_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= avg;
      m_axis_tlast <= ctl.last;
    end
  end

endmodule
